>>> src/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
// Used by lfu_mem, lfu_scan and the top level lfu_cache_lru_tiebreak.
`default_nettype none

package lfu_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 7;
	localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 32;
	localparam int STAMP_W = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam logic [0:0] ACT_GET = 1'b0;
	localparam logic [0:0] ACT_PUT = 1'b1;

	// one entry row of the memory
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} row_t;

	// what one walk over the entries found
	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic [VAL_W-1:0]   hit_value;
		logic [COUNT_W-1:0] hit_count;
		logic               vic;
		logic [IDX_W-1:0]   vic_idx;
		logic               free;
		logic [IDX_W-1:0]   free_idx;
	} scan_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WB
	} st_t;

endpackage

`default_nettype wire

>>> src/lfu_mem.sv
// Entry memory: one write port, one read port, registered read data.
// Depends on lfu_pkg for the row type and depth.
`default_nettype none

module lfu_mem (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [lfu_pkg::IDX_W-1:0] rd_addr,
	output lfu_pkg::row_t                  rd_data,
	input  wire logic                      wr_en,
	input  wire logic [lfu_pkg::IDX_W-1:0] wr_addr,
	input  wire lfu_pkg::row_t             wr_data
);
	import lfu_pkg::*;

	row_t mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/lfu_scan.sv
// Walk tracker: folds the stream of read rows into key match, LFU/LRU victim
// and first free slot. Depends on lfu_pkg.
`default_nettype none

module lfu_scan (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      chk,
	input  wire logic [lfu_pkg::IDX_W-1:0] idx,
	input  wire logic                      vld,
	input  wire lfu_pkg::row_t             row,
	input  wire logic [lfu_pkg::KEY_W-1:0] key,
	output lfu_pkg::scan_res_t             res
);
	import lfu_pkg::*;

	logic               hit_q, vic_q, free_q;
	logic [IDX_W-1:0]   hit_idx_q, vic_idx_q, free_idx_q;
	logic [VAL_W-1:0]   hit_value_q;
	logic [COUNT_W-1:0] hit_count_q, vic_count_q;
	logic [STAMP_W-1:0] vic_stamp_q;
	logic               take_hit, take_vic, take_free, older;

	// lower count wins; on equal count the older stamp wins
	assign older = (row.count < vic_count_q) ||
		((row.count == vic_count_q) && (row.stamp < vic_stamp_q));
	assign take_hit  = chk && vld && !hit_q && (row.key == key);
	assign take_vic  = chk && vld && (!vic_q || older);
	assign take_free = chk && !vld && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (start) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (take_hit)  hit_q  <= 1'b1;
			if (take_vic)  vic_q  <= 1'b1;
			if (take_free) free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q   <= idx;
			hit_value_q <= row.value;
			hit_count_q <= row.count;
		end
		if (take_vic) begin
			vic_idx_q   <= idx;
			vic_count_q <= row.count;
			vic_stamp_q <= row.stamp;
		end
		if (take_free) begin
			free_idx_q <= idx;
		end
	end

	always_comb begin
		res.hit       = hit_q;
		res.hit_idx   = hit_idx_q;
		res.hit_value = hit_value_q;
		res.hit_count = hit_count_q;
		res.vic       = vic_q;
		res.vic_idx   = vic_idx_q;
		res.free      = free_q;
		res.free_idx  = free_idx_q;
	end

endmodule

`default_nettype wire

>>> src/lfu_cache_lru_tiebreak.sv
// Top level of the LFU key-value cache with LRU tie-break: sequencer, valid
// bits, occupancy, event clock, result register. Uses lfu_pkg, lfu_mem, lfu_scan.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata: key, value; tuser: action
// m_axis    out  m_axis_tvalid/tready    tdata: read_value; tuser: found
// cfg       in   cfg_we                  cfg_wdata: capacity_in_use
//
// Each item is walked in full before the next accept: the single read port of
// the entry memory is walked once over every entry, one read per cycle, then a
// writeback commits the item.
// Reset clears valid bits, occupancy, event clock and all control state;
// capacity returns to 64. No clearing pass is needed.
// A result waiting on m_axis does not block the next accept; the writeback
// of the following item holds until the result register is free.
`default_nettype none

module lfu_cache_lru_tiebreak (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [31:0] key, [63:32] value
	input  wire logic [0:0]  s_axis_tuser,  // [0] action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [31:0] read_value
	output logic [0:0]       m_axis_tuser,  // [0] found
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata      // [6:0] capacity_in_use
);
	import lfu_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	st_t                state_q, state_d;
	logic               rd_en, start, wb_en;

	// item held for the whole walk
	logic [0:0]         act_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;

	logic [CAP_W-1:0]   cap_q;
	logic [OCC_W-1:0]   occ_q;
	logic [STAMP_W-1:0] clock_q;
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] valid_d;

	logic [IDX_W-1:0]   rd_idx_q;
	logic               issue_done_q;
	logic               chk_s1;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               out_valid_q;
	logic [0:0]         out_found_q;
	logic [VAL_W-1:0]   out_rval_q;

	row_t               rd_row, wr_row;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	scan_res_t          res;

	logic [CMP_W-1:0]   eff_cap;
	logic               full, evict, ins, promote;
	logic [IDX_W-1:0]   slot;
	logic [COUNT_W-1:0] inc_count;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_rval_q;
	assign m_axis_tuser  = out_found_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (chk_s1 && (idx_s1 == LAST_IDX)) state_d = ST_WB;
			end
			ST_WB: begin
				if (wb_en) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_en = 1'b0;
		start = 1'b0;
		wb_en = 1'b0;
		case (state_q)
			ST_IDLE: start = s_axis_tvalid;
			ST_SCAN: rd_en = !issue_done_q;
			ST_WB:   wb_en = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// latch the item on accept
	always_ff @(posedge clk) begin
		if (start) begin
			act_q <= s_axis_tuser;
			key_q <= s_axis_tdata[31:0];
			val_q <= s_axis_tdata[63:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// read issue: one entry per cycle; the tag is registered alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			chk_s1       <= 1'b0;
		end else begin
			chk_s1 <= rd_en;
			if (start) begin
				rd_idx_q     <= '0;
				issue_done_q <= 1'b0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				if (rd_idx_q == LAST_IDX) issue_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_idx_q;
			vld_s1 <= valid_q[rd_idx_q];
		end
	end

	lfu_mem u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_row),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_row)
	);

	lfu_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.chk    (chk_s1),
		.idx    (idx_s1),
		.vld    (vld_s1),
		.row    (rd_row),
		.key    (key_q),
		.res    (res)
	);

	// writeback decisions; capacity clamps to 1..ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
		full      = CMP_W'(occ_q) >= eff_cap;
		promote   = res.hit;
		evict     = (act_q == ACT_PUT) && !res.hit && (full || !res.free) && res.vic;
		ins       = (act_q == ACT_PUT) && !res.hit && (res.free || res.vic);
		slot      = (!res.free || (evict && (res.vic_idx < res.free_idx))) ?
			res.vic_idx : res.free_idx;
		inc_count = (res.hit_count == '1) ? res.hit_count : res.hit_count + COUNT_W'(1);

		wr_row.key   = key_q;
		wr_row.stamp = clock_q;
		if (promote) begin
			wr_row.value = (act_q == ACT_PUT) ? val_q : res.hit_value;
			wr_row.count = inc_count;
			wr_addr      = res.hit_idx;
		end else begin
			wr_row.value = val_q;
			wr_row.count = COUNT_W'(1);
			wr_addr      = slot;
		end
		wr_en = wb_en && (promote || ins);
	end

	// clear the victim, then mark the newcomer (it may reuse the victim's slot)
	always_comb begin
		valid_d = valid_q;
		if (evict) valid_d[res.vic_idx] = 1'b0;
		if (ins) valid_d[slot] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			clock_q <= '0;
		end else if (wb_en) begin
			if (promote || ins) clock_q <= clock_q + STAMP_W'(1);
			valid_q <= valid_d;
			// drop one for the victim, add one for the newcomer
			occ_q <= occ_q - OCC_W'(evict && (occ_q != '0)) + OCC_W'(ins);
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_en) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			out_found_q <= res.hit;
			if (act_q == ACT_PUT) begin
				out_rval_q <= '0;
			end else if (res.hit) begin
				out_rval_q <= res.hit_value;
			end else begin
				out_rval_q <= '1;
			end
		end
	end

	// occupancy tracks the valid bits exactly
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy out of step with valid bits");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(ENTRIES))
		else $error("occupancy above entry count");

	// the event clock moves only at a committed writeback
	a_clock_only_at_wb: assert property (@(posedge clk) disable iff (!arst_n)
		!wb_en |=> $stable(clock_q))
		else $error("event clock moved outside writeback");

	// read data is checked only while walking
	a_chk_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> (state_q == ST_SCAN))
		else $error("read data checked outside walk");

	// a put of a new key always finds a place
	a_put_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_en && (act_q == ACT_PUT) && !res.hit) |-> (res.free || res.vic))
		else $error("put miss with no free slot and no victim");

endmodule

`default_nettype wire

>>> sim/lfu_cache_lru_tiebreak_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lfu_cache_lru_tiebreak: directed and random get/put traffic
// with random stalls, checked against a shadow LFU cache with least-recently-used
// tie-break. Depends on lfu_pkg and the RTL of the block only.

module lfu_cache_lru_tiebreak_tb;

	import lfu_pkg::*;

	localparam int CLK_HALF   = 10;
	localparam int CYCLE_CAP  = 1_000_000;
	localparam int RAND_ITEMS = 180;

	// one expected reply: hit flag and returned value
	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] value;
	} reply_t;

	// Shadow cache: its own copy of the entry store, event clock, occupancy and
	// capacity, plus the queue of replies that accepted items still owe.
	class lfu_shadow;
		bit                 valid [ENTRIES];
		logic [KEY_W-1:0]   keys  [ENTRIES];
		logic [VAL_W-1:0]   vals  [ENTRIES];
		logic [COUNT_W-1:0] uses  [ENTRIES];
		logic [STAMP_W-1:0] stamps[ENTRIES];
		logic [STAMP_W-1:0] event_clk;
		int unsigned        occ;
		int unsigned        cap;
		reply_t             replies[$];
		int unsigned        mismatches;

		function new();
			for (int i = 0; i < ENTRIES; i++) valid[i] = 1'b0;
			event_clk  = '0;
			occ        = 0;
			cap        = CAP_RESET;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			cap = c;
		endfunction

		function int pending();
			return replies.size();
		endfunction

		// raise the count (saturating) and restamp
		function void promote(int i);
			if (uses[i] != '1) uses[i] = uses[i] + 1'b1;
			stamps[i] = event_clk;
			event_clk = event_clk + 1'b1;
		endfunction

		// work out the reply of one accepted item and update the shadow state
		function void note_request(logic [0:0] act, logic [KEY_W-1:0] k,
				logic [VAL_W-1:0] v);
			int          hit;
			int          victim;
			int          free_slot;
			int unsigned eff_cap;
			reply_t      r;
			hit       = -1;
			victim    = -1;
			free_slot = -1;
			eff_cap   = (cap < 1) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid[i]) begin
					if (hit < 0 && keys[i] == k) hit = i;
					if (victim < 0 || uses[i] < uses[victim] ||
							(uses[i] == uses[victim] && stamps[i] < stamps[victim]))
						victim = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (act == ACT_GET) begin
				if (hit >= 0) begin
					promote(hit);
					r.found = 1'b1;
					r.value = vals[hit];
				end else begin
					r.found = 1'b0;
					r.value = '1;
				end
			end else begin
				r.value = '0;
				r.found = (hit >= 0);
				if (hit >= 0) begin
					vals[hit] = v;
					promote(hit);
				end else begin
					if ((occ >= eff_cap || free_slot < 0) && victim >= 0) begin
						valid[victim] = 1'b0;
						if (occ > 0) occ--;
						if (free_slot < 0 || victim < free_slot) free_slot = victim;
					end
					if (free_slot >= 0) begin
						valid[free_slot]  = 1'b1;
						keys[free_slot]   = k;
						vals[free_slot]   = v;
						uses[free_slot]   = 1;
						stamps[free_slot] = event_clk;
						event_clk         = event_clk + 1'b1;
						occ++;
					end
				end
			end
			replies = {replies, r};
		endfunction

		// compare one reply from the block with the oldest one owed
		function void check_response(logic found, logic [VAL_W-1:0] got);
			reply_t want;
			if (replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected reply: found=%0b read_value=%h",
						$realtime, found, got);
				return;
			end
			want = replies[0];
			replies.delete(0);
			if (want.found !== found || want.value !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] reply mismatch: found exp %0b got %0b, read_value exp %h got %h",
						$realtime, want.found, found, want.value, got);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [63:0]        s_axis_tdata;
	logic [0:0]         s_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [31:0]        m_axis_tdata;
	logic [0:0]         m_axis_tuser;
	logic               cfg_we;
	logic [CAP_W-1:0]   cfg_wdata;

	lfu_shadow          shadow;
	bit                 idling;      // random gaps and stalls allowed
	int unsigned        stall_left = 0;
	int unsigned        cycles = 0;
	logic [KEY_W-1:0]   key_pool[128];

	lfu_cache_lru_tiebreak DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [31:0] key, [63:32] value
		.s_axis_tuser  (s_axis_tuser),   // [0] action
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [31:0] read_value
		.m_axis_tuser  (m_axis_tuser),   // [0] found
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)       // [6:0] capacity_in_use
	);

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// Watchdog: ends the run as failed at the cycle cap.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Reply side: check every accepted reply, then pick the next tready.
	// Random stall bursts on tready come only when idling is on.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			shadow.check_response(m_axis_tuser[0], m_axis_tdata);
		if (!arst_n || !idling) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Offer one item and hold it until the block takes it. An optional gap
	// of random length drops tvalid first; without a gap tvalid stays high.
	task automatic send_item(input logic [0:0] act, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {v, k};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		shadow.note_request(act, k, v);
	endtask

	// Drop tvalid and wait for every owed reply; every item yields one reply,
	// so an empty queue means the block is idle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
	endtask

	// Write capacity_in_use; only called with the block drained.
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		cfg_wdata <= c;
		cfg_we    <= 1'b1;
		@(posedge clk);
		shadow.set_capacity(c);
		cfg_we    <= 1'b0;
	endtask

	// Random get/put traffic at one capacity. Most keys come from a pool a bit
	// larger than the capacity, so hits, updates and evictions all happen; the
	// rest are fresh random keys. Short get bursts on a recent key build up
	// uneven use counts for the tie-break.
	task automatic run_traffic(input int n, input logic [CAP_W-1:0] c);
		int               pool_n;
		int               sent;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] last_key;
		drain();
		write_capacity(c);
		pool_n   = c + c / 2 + 2;
		last_key = '0;
		for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(2, 4)) begin
					send_item(ACT_GET, last_key, $urandom);
					sent++;
				end
			end else begin
				k = ($urandom_range(0, 7) == 0) ? $urandom
					: key_pool[$urandom_range(0, pool_n - 1)];
				if ($urandom_range(0, 99) < 55) begin
					send_item(ACT_PUT, k, $urandom);
					last_key = k;
				end else begin
					send_item(ACT_GET, k, $urandom);
				end
				sent++;
			end
		end
	endtask

	initial begin
		shadow        = new();
		idling        = 1'b1;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_GET;
		cfg_we        = 1'b0;
		cfg_wdata     = CAP_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-cache miss, extreme keys and values, hits, a hit that
		// returns all ones, a miss, updates of present keys.
		send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
		send_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_item(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
		send_item(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
		send_item(ACT_GET, 32'h1234_5678, 32'h0000_0000);
		send_item(ACT_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
		send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
		send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h0000_0001);

		// Capacity lowered below occupancy: new keys shed one victim each,
		// lowest count first, least recently used among equal counts.
		drain();
		write_capacity(CAP_W'(2));
		send_item(ACT_PUT, 32'h0000_0011, 32'h0000_0011);
		send_item(ACT_PUT, 32'h0000_0022, 32'h0000_0022);
		send_item(ACT_PUT, 32'h0000_0033, 32'h0000_0033);
		send_item(ACT_GET, 32'h0000_0011, 32'h0000_0000);
		send_item(ACT_GET, 32'h0000_0022, 32'h0000_0000);
		send_item(ACT_PUT, 32'h0000_0044, 32'h0000_0044);
		send_item(ACT_GET, 32'h0000_0033, 32'h0000_0000);
		send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);

		// Capacity of one: every new key evicts one victim.
		drain();
		write_capacity(CAP_W'(1));
		send_item(ACT_PUT, 32'h0000_0055, 32'hA5A5_A5A5);
		send_item(ACT_GET, 32'h0000_0055, 32'h0000_0000);
		send_item(ACT_PUT, 32'h0000_0066, 32'h0F0F_0F0F);
		send_item(ACT_GET, 32'h0000_0055, 32'h0000_0000);

		// Random phases across the capacity range, extremes included.
		run_traffic(RAND_ITEMS, CAP_W'(1));
		run_traffic(RAND_ITEMS, CAP_W'(7));
		run_traffic(RAND_ITEMS, CAP_W'(64));
		run_traffic(RAND_ITEMS, CAP_W'(16));
		run_traffic(RAND_ITEMS, CAP_W'(3));
		run_traffic(RAND_ITEMS, CAP_W'(40));
		run_traffic(RAND_ITEMS, CAP_W'(2));
		run_traffic(RAND_ITEMS, CAP_W'(64));
		// last stretch at full rate on both sides
		idling = 1'b0;
		run_traffic(RAND_ITEMS, CAP_W'(5));

		drain();
		repeat (ENTRIES + 16) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/lfu_pkg.sv
src/lfu_mem.sv
src/lfu_scan.sv
src/lfu_cache_lru_tiebreak.sv
sim/lfu_cache_lru_tiebreak_tb.sv
